FILE: rtl/core/slcan_pkg.sv
// Shared types and constants of the serial CAN command line parser.
package slcan_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [31:0] MODE_ID = 32'h0000_022A;

    typedef enum logic [1:0] {
        EV_CHAR,
        EV_EOL,
        EV_OVERFLOW
    } t_event;

    typedef struct packed {
        t_event     kind;
        logic [7:0] data;
    } t_request;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECODE,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic [7:0]  reply_char;
        logic        reply_last;
        logic        tx_valid;
        logic [31:0] tx_id;
        logic        tx_extended;
        logic        tx_rtr;
        logic [3:0]  tx_length;
        logic [63:0] tx_data;
        logic [3:0]  bitrate_index;
        logic [4:0]  status_flags;
    } t_result;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/slcan_front.sv
// Front part: classifies received bytes and tracks the line length.
module slcan_front #(
    parameter int LINE_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_q_push,
    output slcan_pkg::t_request o_q_req
);
    import slcan_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          w_take;

    assign o_full = i_q_full;
    assign w_take = i_push && !i_q_full;

    always_comb begin
        n_len = r_len;
        o_q_push = 1'b0;
        o_q_req.kind = EV_CHAR;
        o_q_req.data = i_rx_byte;
        if (w_take) begin
            if (i_rx_byte == CH_CR) begin
                o_q_push = 1'b1;
                o_q_req.kind = EV_EOL;
                n_len = '0;
            end else if (i_rx_byte == CH_LF || i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                n_len = r_len;
            end else if (r_len < LW'(LINE_BYTES - 1)) begin
                o_q_push = 1'b1;
                n_len = r_len + 1'b1;
            end else begin
                o_q_push = 1'b1;
                o_q_req.kind = EV_OVERFLOW;
                n_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> w_take)
        else $error("queue written without an accepted byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_rx_byte == CH_CR) |=> r_len == '0)
        else $error("line length not cleared at end of line");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LINE_BYTES - 1))
        else $error("line length beyond buffer");

endmodule

FILE: rtl/core/slcan_queue.sv
// Short request queue between the front and the back part.
module slcan_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  slcan_pkg::t_request i_req,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output slcan_pkg::t_request o_req
);
    import slcan_pkg::*;

    t_request   r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 3'(i_push && !o_full) - 3'(i_pop && !o_empty);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !(i_pop && !o_empty)) |=> o_full)
        else $error("queue full flag dropped without a read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !(i_push && !o_full)) |=> o_empty)
        else $error("queue empty flag dropped without a write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("queue count overflow");

endmodule

FILE: rtl/core/slcan_back.sv
// Back part: stores the line, decodes commands and emits reply bytes.
module slcan_back #(
    parameter int LINE_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  slcan_pkg::t_request i_q_req,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output slcan_pkg::t_result  o_res
);
    import slcan_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam int LN = LINE_BYTES - 1;

    logic [7:0]    r_store [LN];
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_pos;
    logic [7:0]    r_rd;
    t_state        r_state;
    t_state        n_state;
    logic          r_open, r_listen, r_ts, r_charge, r_dcdc;
    logic [3:0]    r_rate;
    logic [7:0]    r_cmd;
    logic [7:0]    r_arg1;
    logic [31:0]   r_id;
    logic [63:0]   r_data;
    logic [3:0]    r_dlc;
    logic          r_bad;
    logic [63:0]   r_reply;
    logic [2:0]    r_nrep;
    logic [2:0]    r_ridx;
    logic          r_sent;
    logic          r_outv;
    t_result       r_out;

    logic          w_tx, w_ext, w_rtr, w_last_pos;
    logic [3:0]    w_idn;
    logic [LW-1:0] w_pos;
    logic [4:0]    w_hv;
    logic          w_emit;
    logic [7:0]    w_cmd;

    assign w_tx  = r_cmd == "t" || r_cmd == "T" || r_cmd == "r" || r_cmd == "R";
    assign w_ext = r_cmd == "T" || r_cmd == "R";
    assign w_rtr = r_cmd == "r" || r_cmd == "R";
    assign w_idn = w_ext ? 4'd8 : 4'd3;
    assign w_hv  = hex_value(r_rd);
    assign w_pos = r_pos - 1'b1;
    assign w_cmd = (r_len == LW'(1)) ? r_rd : r_cmd;
    assign w_emit = r_state == ST_REPLY && (!r_outv || i_pop);
    assign o_q_pop = r_state == ST_IDLE && !i_q_empty;
    assign o_empty = !r_outv;
    assign o_res = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_req.kind == EV_OVERFLOW) begin
                        n_state = ST_REPLY;
                    end else if (i_q_req.kind == EV_EOL && r_len != '0) begin
                        n_state = w_last_pos ? ST_DECODE : ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (r_pos == r_len) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: n_state = ST_REPLY;
            ST_REPLY: begin
                if (w_emit && r_ridx + 3'd1 == r_nrep) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_last_pos = r_len == LW'(1);

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_req.kind == EV_CHAR) begin
            r_store[r_len[LW-1:0]] <= i_q_req.data;
        end
        r_rd <= r_store[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len <= '0;
            r_open <= 1'b0;
            r_listen <= 1'b0;
            r_ts <= 1'b0;
            r_charge <= 1'b0;
            r_dcdc <= 1'b0;
            r_rate <= 4'd6;
            r_outv <= 1'b0;
            r_ridx <= '0;
            r_nrep <= '0;
            r_sent <= 1'b0;
            r_pos <= '0;
        end else begin
            r_state <= n_state;
            if (r_outv && i_pop) begin
                r_outv <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_pos <= '0;
                    r_bad <= 1'b0;
                    r_id <= '0;
                    r_data <= '0;
                    r_dlc <= '0;
                    r_ridx <= '0;
                    r_sent <= 1'b0;
                    r_arg1 <= '0;
                    if (!i_q_empty) begin
                        case (i_q_req.kind)
                            EV_CHAR: r_len <= r_len + 1'b1;
                            EV_OVERFLOW: begin
                                r_len <= '0;
                                r_reply <= {CH_BEL, 56'd0};
                                r_nrep <= 3'd1;
                            end
                            default: begin
                                r_pos <= LW'(1);
                            end
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    if (r_pos != r_len) begin
                        r_pos <= r_pos + 1'b1;
                    end
                    if (w_pos == '0) begin
                        r_cmd <= r_rd;
                    end else if (w_pos == LW'(1)) begin
                        r_arg1 <= r_rd;
                    end
                    if (w_pos != '0 && w_tx) begin
                        if (w_pos <= LW'(w_idn)) begin
                            if (w_hv[4]) r_bad <= 1'b1;
                            r_id <= {r_id[27:0], w_hv[3:0]};
                        end else if (w_pos == LW'(w_idn) + 1'b1) begin
                            if (w_hv[4] || w_hv[3:0] > 4'd8) r_bad <= 1'b1;
                            r_dlc <= w_hv[3:0];
                        end else if (!w_rtr && w_pos <= LW'(w_idn) + 1'b1 + LW'({r_dlc, 1'b0}))
                        begin
                            if (w_hv[4]) r_bad <= 1'b1;
                            if (w_pos[0] == w_idn[0]) begin
                                r_data <= {w_hv[3:0], r_data[63:4]};
                            end else begin
                                r_data <= {r_data[63:60], w_hv[3:0], r_data[59:4]};
                            end
                        end
                    end
                end
                ST_DECODE: begin
                    r_len <= '0;
                    if (r_len == LW'(1)) begin
                        r_cmd <= r_rd;
                    end
                    r_nrep <= 3'd1;
                    r_reply <= {CH_BEL, 56'd0};
                    case (w_cmd)
                        "S": begin
                            if (r_len == LW'(2) && !r_open && r_arg1 >= "0" && r_arg1 <= "8")
                            begin
                                r_rate <= r_arg1[3:0];
                                r_reply <= {CH_CR, 56'd0};
                            end
                        end
                        "O", "L": begin
                            if (!r_open) begin
                                r_open <= 1'b1;
                                r_listen <= w_cmd == "L";
                                r_reply <= {CH_CR, 56'd0};
                            end
                        end
                        "C": begin
                            r_open <= 1'b0;
                            r_listen <= 1'b0;
                            r_charge <= 1'b0;
                            r_dcdc <= 1'b0;
                            r_reply <= {CH_CR, 56'd0};
                        end
                        "t", "T", "r", "R": begin
                            if (!r_bad && r_len >= LW'(w_idn) + LW'(2)
                                && (w_rtr || r_len >= LW'(w_idn) + LW'(2) + LW'({r_dlc, 1'b0}))
                                && r_open && !r_listen) begin
                                r_sent <= 1'b1;
                                r_nrep <= 3'd2;
                                r_reply <= {w_ext ? "Z" : "z", CH_CR, 48'd0};
                                r_data <= r_data >> (64 - 8 * r_dlc);
                                if (!w_ext && !w_rtr && r_id == MODE_ID && r_dlc >= 4'd3)
                                begin
                                    r_charge <= r_data[(64 - 8 * r_dlc) + 18];
                                    r_dcdc <= r_data[(64 - 8 * r_dlc) + 19];
                                end
                            end
                        end
                        "F": begin
                            r_nrep <= 3'd4;
                            r_reply <= {"F00", CH_CR, 32'd0};
                        end
                        "V": begin
                            r_nrep <= 3'd6;
                            r_reply <= {"V0101", CH_CR, 16'd0};
                        end
                        "v": begin
                            r_nrep <= 3'd6;
                            r_reply <= {"v0100", CH_CR, 16'd0};
                        end
                        "N": begin
                            r_nrep <= 3'd6;
                            r_reply <= {"NPCS1", CH_CR, 16'd0};
                        end
                        "Z": begin
                            if (r_len == LW'(2) && (r_arg1 == "0" || r_arg1 == "1")) begin
                                r_ts <= r_arg1 == "1";
                                r_reply <= {CH_CR, 56'd0};
                            end
                        end
                        "M", "m": r_reply <= {CH_CR, 56'd0};
                        default: r_reply <= {CH_BEL, 56'd0};
                    endcase
                end
                ST_REPLY: begin
                    if (w_emit) begin
                        r_outv <= 1'b1;
                        r_ridx <= r_ridx + 1'b1;
                        r_reply <= {r_reply[55:0], 8'd0};
                    end
                end
                default: r_len <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.reply_char <= r_reply[63:56];
            r_out.reply_last <= r_ridx + 3'd1 == r_nrep;
            r_out.tx_valid <= r_sent && r_ridx == '0;
            r_out.tx_id <= (r_sent && r_ridx == '0) ? r_id : '0;
            r_out.tx_extended <= r_sent && r_ridx == '0 && w_ext;
            r_out.tx_rtr <= r_sent && r_ridx == '0 && w_rtr;
            r_out.tx_length <= (r_sent && r_ridx == '0) ? r_dlc : '0;
            r_out.tx_data <= (r_sent && r_ridx == '0 && !w_rtr) ? r_data : '0;
            r_out.bitrate_index <= r_rate;
            r_out.status_flags <= {r_dcdc, r_charge, r_ts, r_listen, r_open};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_outv)
        else $error("reply byte lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outv && !i_pop) |=> r_outv && $stable(r_out))
        else $error("waiting reply changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_REPLY |-> r_nrep != '0)
        else $error("reply phase without bytes");

endmodule

FILE: rtl/core/slcan_command_line_parser.sv
// Top level of the serial CAN command line parser.
// Timing: a plain byte passes the queue into the stored line; CR walks the stored line
// one byte per cycle, which sets the line rate, then one reply byte per cycle while pop keeps up.
// Throughput: ordinary bytes at 1 per cycle into a 4-entry queue while it is not full.
// Reset is synchronous and active low; it empties the line and restores preset 6.
module slcan_command_line_parser #(
    parameter int LINE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_reply_char,
    output logic        o_reply_last,
    output logic        o_tx_valid,
    output logic [31:0] o_tx_id,
    output logic        o_tx_extended,
    output logic        o_tx_rtr,
    output logic [3:0]  o_tx_length,
    output logic [63:0] o_tx_data,
    output logic [3:0]  o_bitrate_index,
    output logic [4:0]  o_status_flags
);
    import slcan_pkg::*;

    logic     w_qpush, w_qfull, w_qpop, w_qempty;
    t_request w_in_req, w_out_req;
    t_result  w_res;

    slcan_front #(.LINE_BYTES(LINE_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_rx_byte(i_rx_byte),
        .i_q_full(w_qfull), .o_full(full), .o_q_push(w_qpush), .o_q_req(w_in_req)
    );

    slcan_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_qpush), .i_req(w_in_req),
        .o_full(w_qfull), .i_pop(w_qpop), .o_empty(w_qempty), .o_req(w_out_req)
    );

    slcan_back #(.LINE_BYTES(LINE_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_qempty), .i_q_req(w_out_req),
        .o_q_pop(w_qpop), .i_pop(pop), .o_empty(empty), .o_res(w_res)
    );

    assign o_reply_char    = w_res.reply_char;
    assign o_reply_last    = w_res.reply_last;
    assign o_tx_valid      = w_res.tx_valid;
    assign o_tx_id         = w_res.tx_id;
    assign o_tx_extended   = w_res.tx_extended;
    assign o_tx_rtr        = w_res.tx_rtr;
    assign o_tx_length     = w_res.tx_length;
    assign o_tx_data       = w_res.tx_data;
    assign o_bitrate_index = w_res.bitrate_index;
    assign o_status_flags  = w_res.status_flags;

endmodule
